@@ hdl/jlpg_pkg.sv @@
`default_nettype none
package jlpg_pkg;

  localparam int RATE_BITS_DEF = 32;
  localparam int POSITION_BITS_DEF = 48;
  localparam int PERIOD_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int MODE_BITS = 3;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MAX_VEL  = 3'd0,
    REG_MAX_ACC  = 3'd1,
    REG_MAX_JERK = 3'd2,
    REG_ZEROBAND = 3'd3,
    REG_VEL_TOL  = 3'd4,
    REG_PERIOD   = 3'd5
  } cfg_reg_t;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_BRAKE = 3'd0,
    MODE_HOLD  = 3'd1,
    MODE_ACCEL = 3'd2,
    MODE_DECEL = 3'd3,
    MODE_KEEP  = 3'd4
  } motion_mode_t;

endpackage
`default_nettype wire

@@ hdl/jerk_limited_position_generator_unit.sv @@
// An accepted input word steps through S_JERK, S_DEC, S_VEL and S_POS; the result word is registered
// in S_POS. No new word is taken until the unit is back in S_IDLE. One shared 33-by-17-bit multiplier
// serves jerk, acceleration and velocity products in turn; a result left waiting holds the next item
// in its last step until the output register frees.
// Reset (rst_n low, synchronous): position, velocity, acceleration, limit and period registers clear,
// no result pending.
`default_nettype none
module jerk_limited_position_generator_unit #(
  parameter int RATE_BITS = jlpg_pkg::RATE_BITS_DEF,
  parameter int POSITION_BITS = jlpg_pkg::POSITION_BITS_DEF,
  localparam int IN_DW = ((RATE_BITS + POSITION_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((POSITION_BITS + 2 * RATE_BITS + 7) / 8) * 8
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [jlpg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [RATE_BITS-1:0]                cfg_data,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // velocity_command, position_value, zero pad
  input  wire logic [IN_DW-1:0]                    in_tdata,
  // load_position
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // new_position, new_velocity, new_acceleration, zero pad
  output logic [OUT_DW-1:0]                        out_tdata,
  // motion_mode
  output logic [jlpg_pkg::MODE_BITS-1:0]           out_tuser
);

  localparam int RB = RATE_BITS;
  localparam int PB = POSITION_BITS;
  localparam int PRB = jlpg_pkg::PERIOD_BITS;
  localparam int XW = RB + 2;
  localparam int MW = RB + 1;
  localparam int PW = MW + PRB + 1;
  localparam int SW = ((PB > XW) ? PB : XW) + 1;

  typedef enum logic [2:0] {S_IDLE, S_JERK, S_DEC, S_VEL, S_POS} state_t;

  state_t state_r;
  logic [RB-2:0] vmax_r, amax_r, jmax_r, zb_r, tol_r;
  logic [PRB-1:0] tp_r;
  logic signed [PB-1:0] pos_r;
  logic signed [RB-1:0] vel_r, acc_r;
  logic signed [XW-1:0] cmd_r, sp_r, jp_r, vfix_r;
  logic vint_r;
  logic signed [MW-1:0] mul_a_r;
  logic signed [RB-1:0] accn_r, veln_r;
  logic [jlpg_pkg::MODE_BITS-1:0] mode_r;
  logic out_valid_r;
  logic [OUT_DW-1:0] out_data_r;
  logic [jlpg_pkg::MODE_BITS-1:0] out_mode_r;

  logic signed [PW-1:0] prod;
  logic signed [XW-1:0] prod_hi;
  assign prod = $signed({{(PW-MW){mul_a_r[MW-1]}}, mul_a_r})
              * $signed({{(PW-PRB){1'b0}}, tp_r});
  // product >> 16, rounding toward minus infinity
  assign prod_hi = prod[PW-1 -: XW];

  logic signed [XW-1:0] vmaxx, amaxx, zbx, tolx, vpx, a0x, cmdx;
  assign vmaxx = $signed({3'b000, vmax_r});
  assign amaxx = $signed({3'b000, amax_r});
  assign zbx = $signed({3'b000, zb_r});
  assign tolx = $signed({3'b000, tol_r});
  assign vpx = $signed({{2{vel_r[RB-1]}}, vel_r});
  assign a0x = $signed({{2{acc_r[RB-1]}}, acc_r});
  assign cmdx = $signed({{2{in_tdata[RB-1]}}, in_tdata[RB-1:0]});

  // mode and acceleration decision
  logic signed [XW-1:0] asum, aramp, anew, vfix;
  logic use_ramp, rneg, vint;
  logic [jlpg_pkg::MODE_BITS-1:0] mode;
  always_comb begin
    use_ramp = 1'b0;
    rneg = 1'b0;
    vint = 1'b1;
    anew = a0x;
    vfix = vpx;
    mode = jlpg_pkg::MODE_KEEP;
    if (sp_r == '0 || (sp_r > 0 && vpx < 0) || (sp_r < 0 && vpx > 0)) begin
      mode = jlpg_pkg::MODE_BRAKE;
      if (vpx > zbx) begin
        use_ramp = 1'b1; rneg = 1'b1;
      end else if (vpx < -zbx) begin
        use_ramp = 1'b1;
      end else if (vpx > tolx) begin
        if (a0x >= 0) anew = -(amaxx >>> 1);
        else use_ramp = 1'b1;
      end else if (vpx < -tolx) begin
        if (a0x <= 0) anew = amaxx >>> 1;
        else begin
          use_ramp = 1'b1; rneg = 1'b1;
        end
      end else if (cmd_r > tolx) begin
        use_ramp = 1'b1;
      end else if (cmd_r < -tolx) begin
        use_ramp = 1'b1; rneg = 1'b1;
      end else begin
        anew = '0; vint = 1'b0; vfix = '0;
      end
    end else if (vpx < sp_r + tolx && vpx > sp_r - tolx) begin
      mode = jlpg_pkg::MODE_HOLD;
      anew = '0; vint = 1'b0;
    end else if (sp_r != vpx) begin
      mode = (sp_r > vpx) ? jlpg_pkg::MODE_ACCEL : jlpg_pkg::MODE_DECEL;
      if ((vpx <<< 1) > sp_r) begin
        use_ramp = 1'b1; rneg = 1'b1;
      end else if ((vpx <<< 1) < sp_r) begin
        use_ramp = 1'b1;
      end else begin
        anew = (sp_r > vpx) ? amaxx : -amaxx;
      end
    end else begin
      vint = 1'b0;
    end
    asum = a0x + (rneg ? -jp_r : jp_r);
    if (asum < -amaxx) aramp = -amaxx;
    else if (asum > amaxx) aramp = amaxx;
    else if ((asum < 0) != (a0x < 0)) aramp = a0x;
    else aramp = asum;
    if (use_ramp) anew = aramp;
  end

  logic signed [XW-1:0] vraw, vclamp;
  always_comb begin
    vraw = vint_r ? vpx + prod_hi : vfix_r;
    if (vraw < -vmaxx) vclamp = -vmaxx;
    else if (vraw > vmaxx) vclamp = vmaxx;
    else vclamp = vraw;
  end

  logic signed [SW-1:0] psum, pmaxw, pminw;
  logic signed [PB-1:0] pnew;
  always_comb begin
    pmaxw = $signed({{(SW-PB+1){1'b0}}, {(PB-1){1'b1}}});
    pminw = -pmaxw - 1;
    psum = $signed({{(SW-PB){pos_r[PB-1]}}, pos_r})
         + $signed({{(SW-XW){prod_hi[XW-1]}}, prod_hi});
    if (psum > pmaxw) pnew = pmaxw[PB-1:0];
    else if (psum < pminw) pnew = pminw[PB-1:0];
    else pnew = psum[PB-1:0];
  end

  logic out_free;
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vmax_r <= '0; amax_r <= '0; jmax_r <= '0;
      zb_r <= '0; tol_r <= '0; tp_r <= '0;
      pos_r <= '0; vel_r <= '0; acc_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          jlpg_pkg::REG_MAX_VEL:  vmax_r <= cfg_data[RB-2:0];
          jlpg_pkg::REG_MAX_ACC:  amax_r <= cfg_data[RB-2:0];
          jlpg_pkg::REG_MAX_JERK: jmax_r <= cfg_data[RB-2:0];
          jlpg_pkg::REG_ZEROBAND: zb_r <= cfg_data[RB-2:0];
          jlpg_pkg::REG_VEL_TOL:  tol_r <= cfg_data[RB-2:0];
          jlpg_pkg::REG_PERIOD:   tp_r <= cfg_data[PRB-1:0];
          default: ;
        endcase
      end
      // in the last step a taken word is replaced by the new one below
      if (out_valid_r && out_tready && state_r != S_POS) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            if (in_tuser) pos_r <= $signed(in_tdata[RB +: PB]);
            cmd_r <= cmdx;
            mul_a_r <= $signed({2'b00, jmax_r});
            state_r <= S_JERK;
          end
        end
        S_JERK: begin
          jp_r <= prod_hi;
          if (cmd_r > vmaxx) sp_r <= vmaxx;
          else if (cmd_r < -vmaxx) sp_r <= -vmaxx;
          else sp_r <= cmd_r;
          state_r <= S_DEC;
        end
        S_DEC: begin
          accn_r <= anew[RB-1:0];
          mul_a_r <= anew[MW-1:0];
          vint_r <= vint;
          vfix_r <= vfix;
          mode_r <= mode;
          state_r <= S_VEL;
        end
        S_VEL: begin
          veln_r <= vclamp[RB-1:0];
          mul_a_r <= vclamp[MW-1:0];
          state_r <= S_POS;
        end
        S_POS: begin
          if (out_free) begin
            pos_r <= pnew;
            vel_r <= veln_r;
            acc_r <= accn_r;
            out_data_r <= OUT_DW'({accn_r, veln_r, pnew});
            out_mode_r <= mode_r;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a word while still busy");

  a_result_from_pos: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_POS))
    else $error("result raised outside final step");

  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= jlpg_pkg::MODE_KEEP)
    else $error("motion mode out of range");

endmodule
`default_nettype wire

@@ tb/sv/jlpg_checker.sv @@
`timescale 1ns / 100ps
`default_nettype none
module jlpg_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [79:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [111:0] out_tdata,
  input  wire logic [2:0]  out_tuser,
  output int               fail_count,
  output int               pending,
  output int               results_seen
);

  typedef struct packed {
    logic [47:0]  pos;
    logic [31:0]  vel;
    logic [31:0]  acc;
    jlpg_pkg::motion_mode_t mode;
  } motion_state_t;

  motion_state_t expected_motion[$];

  longint vmax_q, amax_q, jerk_q, zb_q, tol_q, period_q;
  longint pos_q, vel_q, acc_q;

  function automatic longint floor_shift16(longint x);
    return x >>> 16;
  endfunction

  function automatic longint scale_by_period(longint r);
    return floor_shift16(r * period_q);
  endfunction

  // acceleration moves by delta, clamped, no sign flip; velocity follows
  task automatic ramp_step(input longint delta, output longint a, output longint v);
    a = acc_q + delta;
    if (a < -amax_q) a = -amax_q;
    else if (a > amax_q) a = amax_q;
    else if ((a < 0) != (acc_q < 0)) a = acc_q;
    v = vel_q + scale_by_period(a);
  endtask

  task automatic predict_motion(input logic [31:0] cmd_bits, input logic load,
                                input logic [47:0] pos_bits);
    longint cmd, sp, jp, vp, a, v, stp, pmax, pmin, p;
    jlpg_pkg::motion_mode_t m;
    motion_state_t r;
    cmd = longint'($signed(cmd_bits));
    jp = floor_shift16(jerk_q * period_q);
    vp = vel_q;
    a = acc_q;
    v = vel_q;
    if (load) pos_q = longint'($signed(pos_bits));
    sp = cmd > vmax_q ? vmax_q : (cmd < -vmax_q ? -vmax_q : cmd);
    if (sp == 0 || (sp > 0 && vp < 0) || (sp < 0 && vp > 0)) begin
      m = jlpg_pkg::MODE_BRAKE;
      if (vp > zb_q) ramp_step(-jp, a, v);
      else if (vp < -zb_q) ramp_step(jp, a, v);
      else if (vp > tol_q) begin
        if (acc_q >= 0) begin
          a = -(amax_q >>> 1);
          v = vp + scale_by_period(a);
        end else ramp_step(jp, a, v);
      end else if (vp < -tol_q) begin
        if (acc_q <= 0) begin
          a = amax_q >>> 1;
          v = vp + scale_by_period(a);
        end else ramp_step(-jp, a, v);
      end else if (cmd > tol_q) ramp_step(jp, a, v);
      else if (cmd < -tol_q) ramp_step(-jp, a, v);
      else begin
        a = 0;
        v = 0;
      end
    end else if (vp < sp + tol_q && vp > sp - tol_q) begin
      m = jlpg_pkg::MODE_HOLD;
      a = 0;
      v = vp;
    end else if (sp != vp) begin
      m = sp > vp ? jlpg_pkg::MODE_ACCEL : jlpg_pkg::MODE_DECEL;
      if (2 * vp > sp) ramp_step(-jp, a, v);
      else if (2 * vp < sp) ramp_step(jp, a, v);
      else begin
        a = (m == jlpg_pkg::MODE_ACCEL) ? amax_q : -amax_q;
        v = vp + scale_by_period(a);
      end
    end else begin
      m = jlpg_pkg::MODE_KEEP;
    end
    if (v < -vmax_q) v = -vmax_q;
    else if (v > vmax_q) v = vmax_q;
    pmax = (64'sd1 <<< 47) - 1;
    pmin = -pmax - 1;
    stp = scale_by_period(v);
    p = pos_q;
    if (stp > 0 && p > pmax - stp) p = pmax;
    else if (stp < 0 && p < pmin - stp) p = pmin;
    else p = p + stp;
    pos_q = p;
    vel_q = v;
    acc_q = a;
    r.pos = p[47:0];
    r.vel = v[31:0];
    r.acc = a[31:0];
    r.mode = m;
    expected_motion.push_back(r);
  endtask

  always @(posedge clk) begin
    motion_state_t e;
    if (!rst_n) begin
      vmax_q = 0; amax_q = 0; jerk_q = 0; zb_q = 0; tol_q = 0; period_q = 0;
      pos_q = 0; vel_q = 0; acc_q = 0;
      expected_motion.delete();
      fail_count <= 0;
      results_seen <= 0;
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (jlpg_pkg::cfg_reg_t'(cfg_index))
          jlpg_pkg::REG_MAX_VEL:  vmax_q = {33'd0, cfg_data[30:0]};
          jlpg_pkg::REG_MAX_ACC:  amax_q = {33'd0, cfg_data[30:0]};
          jlpg_pkg::REG_MAX_JERK: jerk_q = {33'd0, cfg_data[30:0]};
          jlpg_pkg::REG_ZEROBAND: zb_q = {33'd0, cfg_data[30:0]};
          jlpg_pkg::REG_VEL_TOL:  tol_q = {33'd0, cfg_data[30:0]};
          jlpg_pkg::REG_PERIOD:   period_q = {48'd0, cfg_data[15:0]};
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_motion(in_tdata[31:0], in_tuser, in_tdata[79:32]);
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (expected_motion.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_motion.pop_front();
          if (out_tdata[47:0] !== e.pos || out_tdata[79:48] !== e.vel ||
              out_tdata[111:80] !== e.acc || out_tuser !== e.mode) begin
            if (fail_count < 10)
              $display("mismatch: exp pos %h vel %h acc %h mode %0d, got %h %h %h %0d",
                       e.pos, e.vel, e.acc, e.mode, out_tdata[47:0], out_tdata[79:48],
                       out_tdata[111:80], out_tuser);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_motion.size();
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_jerk_limited_position_generator_unit.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_jerk_limited_position_generator_unit;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [2:0] out_tuser;
  int fail_count, pending, results_seen;
  int send_gap_pct = 0, recv_gap_pct = 0;
  bit stall_rx = 1'b0;
  int words_sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  jerk_limited_position_generator_unit dut (.*);

  jlpg_checker chk (.*);

  // receiver: random back-pressure, or a long hold while stall_rx is set
  always @(posedge clk) begin
    if (stall_rx) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_gap_pct);
  end

  // valid stays up between writes; set_limits drops it after the last one
  task automatic write_reg(input jlpg_pkg::cfg_reg_t idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_limits(input logic [30:0] vm, am, jk, zb, tl, input logic [15:0] tp);
    write_reg(jlpg_pkg::REG_MAX_VEL, {1'b0, vm});
    write_reg(jlpg_pkg::REG_MAX_ACC, {1'b0, am});
    write_reg(jlpg_pkg::REG_MAX_JERK, {1'b0, jk});
    write_reg(jlpg_pkg::REG_ZEROBAND, {1'b0, zb});
    write_reg(jlpg_pkg::REG_VEL_TOL, {1'b0, tl});
    write_reg(jlpg_pkg::REG_PERIOD, {16'd0, tp});
    cfg_valid <= 1'b0;
  endtask

  // valid stays up for back-to-back words; wait_idle drops it after the last one
  task automatic send_tick(input logic [31:0] cmd, input logic load, input logic [47:0] p);
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_gap_pct) @(posedge clk);
    end
    in_tdata <= {p, cmd};
    in_tuser <= load;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  function automatic logic [31:0] pick_cmd(input logic [31:0] vm);
    int sel;
    sel = $urandom_range(9);
    case (sel)
      0: return $urandom;
      1: return 32'd0;
      2: return vm;
      3: return -vm;
      4: return $urandom_range(200);
      5: return -$urandom_range(200);
      default: return $urandom_range(vm + 1000) - (vm + 1000) / 2;
    endcase
  endfunction

  task automatic random_phase(input int n, input logic [30:0] vm);
    logic [47:0] p;
    repeat (n) begin
      p = 48'({$urandom, $urandom});
      if ($urandom_range(3) == 0)
        p = {1'($urandom_range(1)), 47'h7fff_ffff_fff0 ^ 47'($urandom_range(15))};
      send_tick(pick_cmd({1'b0, vm}), $urandom_range(9) == 0, p);
    end
  endtask

  initial begin
    #20000000;
    $display("[jerk_limited_position_generator_unit] ERROR");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: realistic limits, then ramps, reversals, braking and loads
    set_limits(31'd10 << 16, 31'd4 << 16, 31'd20 << 16, 31'd1 << 16, 31'd256, 16'd6554);
    send_tick(32'd8 << 16, 1'b0, '0);
    repeat (4) send_tick(32'd8 << 16, 1'b0, '0);
    send_tick(32'd100 << 16, 1'b0, '0);
    send_tick(-(32'd5 << 16), 1'b0, '0);
    send_tick(32'd0, 1'b0, '0);
    send_tick(32'h8000_0000, 1'b1, 48'h7fff_ffff_ffff);
    repeat (3) send_tick(32'h7fff_ffff, 1'b0, '0);
    send_tick(32'd0, 1'b1, 48'h8000_0000_0000);
    repeat (3) send_tick(-(32'd10 << 16), 1'b0, '0);
    send_tick(32'd1, 1'b0, '0);
    send_tick(-32'd1, 1'b0, '0);
    send_tick(32'd100, 1'b0, 48'h5555_aaaa_5555);
    wait_idle();
    // zero tolerance lets exact-setpoint and exact-half cases appear
    set_limits(31'd4 << 16, 31'd2 << 16, 31'd2 << 16, 31'd0, 31'd0, 16'hffff);
    repeat (6) send_tick(32'd4 << 16, 1'b0, '0);
    wait_idle();

    send_gap_pct = 12; recv_gap_pct = 52;
    random_phase(170, 31'd50 << 16);
    wait_idle();
    set_limits(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, 16'hffff);
    random_phase(40, 31'h7fff_ffff);
    wait_idle();
    set_limits(31'($urandom), 31'($urandom_range(1 << 20)), 31'($urandom),
               31'($urandom_range(1 << 17)), 31'($urandom_range(3)), 16'($urandom));
    send_gap_pct = 52; recv_gap_pct = 12;
    random_phase(170, 31'd3 << 16);
    wait_idle();
    set_limits(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 16'd0);
    random_phase(20, 31'd0);
    wait_idle();

    set_limits(31'd20 << 16, 31'd8 << 16, 31'd40 << 16, 31'd1 << 15, 31'd0, 16'd3277);
    send_gap_pct = 0; recv_gap_pct = 0;
    // long receiver hold with the sender still pushing
    fork
      begin
        stall_rx = 1'b1;
        repeat (300) @(posedge clk);
        stall_rx = 1'b0;
      end
      random_phase(20, 31'd20 << 16);
    join
    wait_idle();
    random_phase(220, 31'd20 << 16);
    wait_idle();

    $display("ticks sent %0d, results checked %0d, over several limit settings and stalls",
             words_sent, results_seen);
    if (fail_count == 0) $display("[jerk_limited_position_generator_unit] OK");
    else $display("[jerk_limited_position_generator_unit] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
